// ===== hdl/pdpf_pkg.sv =====
package pdpf_pkg;

	// Table and window sizing.
	localparam int TABLE_DEPTH   = 1024;
	localparam int WINDOW_LENGTH = 32;
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
	localparam int WIN_W         = $clog2(WINDOW_LENGTH);

	// One search cell per halving step, plus one cell that resolves the last read.
	localparam int SEARCH_STEPS  = $clog2(TABLE_DEPTH + 1);
	localparam int CELL_COUNT    = SEARCH_STEPS + 1;

	// Field widths.
	localparam int ADDR_W        = 32;
	localparam int TIME_W        = 64;
	localparam int LEN_W         = 16;
	localparam int SLOT_W        = 10;
	localparam int PREFIX_W      = 16;
	localparam int ID_W          = 16;
	localparam int GAP_W         = 32;
	localparam int CFG_W         = 11;
	localparam int WORD_W        = PREFIX_W + ID_W;

	localparam int IN_DATA_W     = 192;
	localparam int OUT_DATA_W    = 72;

	// Request kinds carried in the input tuser.
	localparam logic CMD_PACKET      = 1'b0;
	localparam logic CMD_TABLE_WRITE = 1'b1;

	// Shared 100.64.0.0/10 and multicast 224.0.0.0/4.
	localparam logic [31:0] SHARED_NET  = 32'h6440_0000;
	localparam logic [31:0] SHARED_MASK = 32'hffc0_0000;
	localparam logic [31:0] MCAST_NET   = 32'he000_0000;
	localparam logic [31:0] MCAST_MASK  = 32'hf000_0000;

	// 192.0.0.0/24 is private except for two anycast hosts.
	localparam logic [31:0] SPECIAL_NET   = 32'hc000_0000;
	localparam logic [31:0] SPECIAL_MASK  = 32'hffff_ff00;
	localparam logic [31:0] SPECIAL_HOST0 = 32'hc000_0009;
	localparam logic [31:0] SPECIAL_HOST1 = 32'hc000_000a;

	localparam int PRIV_COUNT = 15;
	localparam logic [31:0] PRIV_NET [PRIV_COUNT] = '{
		32'h0000_0000, 32'h0a00_0000, 32'h7f00_0000,
		32'ha9fe_0000, 32'hac10_0000, 32'hc000_0200,
		32'hc01f_c400, 32'hc034_c100, 32'hc058_6300,
		32'hc0a8_0000, 32'hc0af_3000, 32'hc612_0000,
		32'hc633_6400, 32'hcb00_7100, 32'he000_0000
	};
	localparam logic [31:0] PRIV_MASK [PRIV_COUNT] = '{
		32'hff00_0000, 32'hff00_0000, 32'hff00_0000,
		32'hffff_0000, 32'hfff0_0000, 32'hffff_ff00,
		32'hffff_ff00, 32'hffff_ff00, 32'hffff_ff00,
		32'hffff_0000, 32'hffff_ff00, 32'hfffe_0000,
		32'hffff_ff00, 32'hffff_ff00, 32'hf000_0000
	};

	// State handed from one search cell to the next.
	typedef struct packed {
		logic                live;
		logic                pending;
		logic                done;
		logic [CNT_W-1:0]    lo;
		logic [CNT_W-1:0]    hi;
		logic [CNT_W-1:0]    mid;
		logic [PREFIX_W-1:0] key;
		logic [ID_W-1:0]     id;
	} search_t;

	// Read request from a cell to the shared table port.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

	// One result item.
	typedef struct packed {
		logic             last;
		logic [LEN_W-1:0] len;
		logic [GAP_W-1:0] gap;
		logic [ID_W-1:0]  id;
		logic             known;
		logic             inbound;
	} result_t;

	function automatic logic addr_private(input logic [31:0] addr);
		logic hit;
		hit = ((addr & SPECIAL_MASK) == SPECIAL_NET) &&
			(addr != SPECIAL_HOST0) && (addr != SPECIAL_HOST1);
		for (int i = 0; i < PRIV_COUNT; i++) begin
			hit = hit | ((addr & PRIV_MASK[i]) == PRIV_NET[i]);
		end
		return hit;
	endfunction

	function automatic logic addr_routable(input logic [31:0] addr);
		return !addr_private(addr) && ((addr & SHARED_MASK) != SHARED_NET) &&
			((addr & MCAST_MASK) != MCAST_NET);
	endfunction

endpackage

// ===== hdl/pdpf_ram.sv =====
module pdpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/pdpf_cell.sv =====
module pdpf_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  pdpf_pkg::search_t st_in,
	input  logic [31:0]       rd_data,
	output pdpf_pkg::search_t st_out,
	output pdpf_pkg::rd_req_t rd_req
);

	pdpf_pkg::search_t                 st_q;
	pdpf_pkg::search_t                 nx;
	logic [pdpf_pkg::PREFIX_W-1:0]     entry_prefix;
	logic [pdpf_pkg::CNT_W-1:0]        mid;
	logic                              go;

	// Take over the bounds handed on by the previous cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= st_in;
		end
	end

	assign entry_prefix = rd_data[pdpf_pkg::WORD_W-1:pdpf_pkg::ID_W];

	// Resolve the read issued by the previous cell, then pick the next probe.
	always_comb begin
		nx = st_q;
		if (st_q.live && st_q.pending) begin
			if (entry_prefix == st_q.key) begin
				nx.done = 1'b1;
				nx.id   = rd_data[pdpf_pkg::ID_W-1:0];
			end else if (entry_prefix < st_q.key) begin
				nx.lo = st_q.mid + pdpf_pkg::CNT_W'(1);
			end else begin
				nx.hi = st_q.mid;
			end
		end
		go  = nx.live && !nx.done && (nx.lo < nx.hi);
		mid = nx.lo + ((nx.hi - nx.lo) >> 1);
		nx.mid     = mid;
		nx.pending = go;
	end

	assign st_out      = nx;
	assign rd_req.en   = go;
	assign rd_req.addr = go ? mid[pdpf_pkg::IDX_W-1:0] : '0;

endmodule

// ===== hdl/packet_direction_prefix_features.sv =====
// Packet direction and prefix feature extractor.
// Input channel s_*: one request is either a packet header (tuser = 0) or a
// prefix table write (tuser = 1). Table writes give no result; the table
// must be loaded in ascending prefix order. Configuration channel cfg_*:
// writes the number of valid table entries and is always ready. The user
// must write it only while no packet is in flight; the block does not
// enforce it. Output channel m_*: one result per packet header; tlast
// marks the final packet of each window of 32 packets.
// A packet header runs through a row of twelve search cells, each doing one
// halving step of the binary search against the single read port of the
// table memory. The result is registered in each search cell in turn and
// then in the output register; a new header is accepted only after the
// search for the previous one has finished.
// Reset clears the window position, the previous timestamp, the entry count
// and all handshake state. The table contents are not cleared.
// When the receiver stalls, one finished result waits in the output register
// while the next header is searched; a second finished result is held in a
// skid register, and input stays blocked until that register drains.
module packet_direction_prefix_features (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata, from bit 0: source_address, destination_address, arrival_time_us,
	// frame_length, entry_slot, entry_prefix, entry_id, zero fill.
	input  logic [pdpf_pkg::IN_DATA_W-1:0]      s_tdata,
	// tuser: command.
	input  logic [0:0]                          s_tuser,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pdpf_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	// tdata, from bit 0: inbound, remote_known, prefix_id, gap_us, length_out,
	// zero fill.
	output logic [pdpf_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready
);

	logic [pdpf_pkg::ADDR_W-1:0]   in_src;
	logic [pdpf_pkg::ADDR_W-1:0]   in_dst;
	logic [pdpf_pkg::TIME_W-1:0]   in_time;
	logic [pdpf_pkg::LEN_W-1:0]    in_len;
	logic [pdpf_pkg::SLOT_W-1:0]   in_slot;
	logic [pdpf_pkg::PREFIX_W-1:0] in_prefix;
	logic [pdpf_pkg::ID_W-1:0]     in_id;

	logic                          in_acc;
	logic                          pkt_acc;
	logic                          tbl_we;

	logic [pdpf_pkg::CFG_W-1:0]    used_q;
	logic [pdpf_pkg::CNT_W-1:0]    used_clamp;
	logic [pdpf_pkg::TIME_W-1:0]   last_time_q;
	logic [pdpf_pkg::WIN_W-1:0]    win_q;
	logic                          busy_q;

	logic                          src_priv;
	logic                          dst_priv;
	logic                          src_glob;
	logic                          dst_glob;
	logic                          known;
	logic                          inbound;
	logic [pdpf_pkg::ADDR_W-1:0]   remote;
	logic [pdpf_pkg::TIME_W:0]     time_diff;
	logic [pdpf_pkg::GAP_W-1:0]    gap;
	logic                          win_last;

	pdpf_pkg::result_t             info_q;
	pdpf_pkg::result_t             res;
	pdpf_pkg::result_t             pend_q;
	pdpf_pkg::result_t             out_q;
	logic                          pend_valid_q;
	logic                          out_valid_q;
	logic                          out_free;
	logic                          fin;

	pdpf_pkg::search_t             st_link [pdpf_pkg::CELL_COUNT+1];
	pdpf_pkg::rd_req_t             req     [pdpf_pkg::CELL_COUNT];
	logic [pdpf_pkg::CELL_COUNT-1:0] req_en;
	pdpf_pkg::rd_req_t             rd_sel;
	logic [pdpf_pkg::WORD_W-1:0]   rd_data;

	// Unpack the input request.
	assign in_src    = s_tdata[31:0];
	assign in_dst    = s_tdata[63:32];
	assign in_time   = s_tdata[127:64];
	assign in_len    = s_tdata[143:128];
	assign in_slot   = s_tdata[153:144];
	assign in_prefix = s_tdata[169:154];
	assign in_id     = s_tdata[185:170];

	assign s_tready = !busy_q && !pend_valid_q;
	assign in_acc   = s_tvalid && s_tready;
	assign pkt_acc  = in_acc && (s_tuser[0] == pdpf_pkg::CMD_PACKET);
	assign tbl_we   = in_acc && (s_tuser[0] == pdpf_pkg::CMD_TABLE_WRITE) &&
		(32'(in_slot) < 32'(pdpf_pkg::TABLE_DEPTH));

	// Entry count register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			used_q <= cfg_data;
		end
	end

	assign used_clamp = (32'(used_q) > 32'(pdpf_pkg::TABLE_DEPTH)) ?
		pdpf_pkg::CNT_W'(pdpf_pkg::TABLE_DEPTH) : pdpf_pkg::CNT_W'(used_q);

	// Address classes and direction choice.
	always_comb begin
		src_priv = pdpf_pkg::addr_private(in_src);
		dst_priv = pdpf_pkg::addr_private(in_dst);
		src_glob = pdpf_pkg::addr_routable(in_src);
		dst_glob = pdpf_pkg::addr_routable(in_dst);
		known    = 1'b0;
		inbound  = 1'b0;
		remote   = '0;
		if (src_priv && dst_glob) begin
			known  = 1'b1;
			remote = in_dst;
		end else if (dst_priv && src_glob) begin
			known   = 1'b1;
			inbound = 1'b1;
			remote  = in_src;
		end else if (dst_priv && !src_priv) begin
			inbound = 1'b1;
		end
	end

	// Inter-arrival gap, zero at window start or when time runs backwards.
	assign time_diff = {1'b0, in_time} - {1'b0, last_time_q};
	always_comb begin
		if ((win_q == '0) || time_diff[pdpf_pkg::TIME_W]) begin
			gap = '0;
		end else if (|time_diff[pdpf_pkg::TIME_W-1:pdpf_pkg::GAP_W]) begin
			gap = '1;
		end else begin
			gap = time_diff[pdpf_pkg::GAP_W-1:0];
		end
	end

	assign win_last = (win_q == pdpf_pkg::WIN_W'(pdpf_pkg::WINDOW_LENGTH - 1));

	// Window position, last timestamp and search busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			win_q       <= '0;
			busy_q      <= 1'b0;
		end else begin
			if (pkt_acc) begin
				last_time_q <= in_time;
				win_q       <= win_last ? '0 : win_q + pdpf_pkg::WIN_W'(1);
				busy_q      <= 1'b1;
			end else if (fin) begin
				busy_q      <= 1'b0;
			end
		end
	end

	// Side fields wait here while the search runs.
	always_ff @(posedge clk) begin
		if (pkt_acc) begin
			info_q.inbound <= inbound;
			info_q.known   <= known;
			info_q.id      <= '0;
			info_q.gap     <= gap;
			info_q.len     <= in_len;
			info_q.last    <= win_last;
		end
	end

	// Launch a search; with no remote the range is empty and the id stays zero.
	always_comb begin
		st_link[0]         = '0;
		st_link[0].live    = pkt_acc;
		st_link[0].hi      = known ? used_clamp : '0;
		st_link[0].key     = remote[pdpf_pkg::ADDR_W-1:pdpf_pkg::ADDR_W-pdpf_pkg::PREFIX_W];
	end

	// Row of search cells.
	for (genvar k = 0; k < pdpf_pkg::CELL_COUNT; k++) begin : g_cell
		pdpf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.st_in   (st_link[k]),
			.rd_data (rd_data),
			.st_out  (st_link[k+1]),
			.rd_req  (req[k])
		);
		assign req_en[k] = req[k].en;
	end

	// Only one cell probes at a time, so the requests are merged by OR.
	always_comb begin
		rd_sel = '0;
		for (int k = 0; k < pdpf_pkg::CELL_COUNT; k++) begin
			rd_sel.en   = rd_sel.en | req[k].en;
			rd_sel.addr = rd_sel.addr | req[k].addr;
		end
	end

	pdpf_ram #(
		.WIDTH (pdpf_pkg::WORD_W),
		.DEPTH (pdpf_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (pdpf_pkg::IDX_W'(in_slot)),
		.wdata ({in_prefix, in_id}),
		.re    (rd_sel.en),
		.raddr (rd_sel.addr),
		.rdata (rd_data)
	);

	// Finished search.
	assign fin = st_link[pdpf_pkg::CELL_COUNT].live;
	always_comb begin
		res    = info_q;
		res.id = st_link[pdpf_pkg::CELL_COUNT].id;
	end

	// Output register with one skid entry behind it.
	assign out_free = !out_valid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q  <= fin;
				end
			end else if (fin) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (fin) begin
				out_q <= res;
			end
		end else if (fin) begin
			pend_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.last;
	assign m_tdata  = pdpf_pkg::OUT_DATA_W'({out_q.len, out_q.gap, out_q.id,
		out_q.known, out_q.inbound});

	// At most one cell reads the table in any cycle.
	a_one_reader: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(req_en))
		else $error("two search cells read the table at once");

	// A search only finishes while a packet is in flight.
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> busy_q)
		else $error("search finished with no packet in flight");

	// A finished result never meets a full skid register.
	a_fin_room: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !pend_valid_q)
		else $error("result finished while skid register full");

	// The skid register is used only behind a full output register.
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("skid register full with output register empty");

	// An accepted packet header starts a search.
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_acc |=> (busy_q && st_link[1].live))
		else $error("packet header accepted without a search");

endmodule

// ===== dv/packet_direction_prefix_features_tb.sv =====
module packet_direction_prefix_features_tb;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = 30;
	localparam int HOLD_OFF_CYCLES = 400;

	// Private networks as base address and prefix length.
	localparam logic [31:0] LAN_NETS [15] = '{
		32'h0000_0000, 32'h0a00_0000, 32'h7f00_0000,
		32'ha9fe_0000, 32'hac10_0000, 32'hc000_0200,
		32'hc01f_c400, 32'hc034_c100, 32'hc058_6300,
		32'hc0a8_0000, 32'hc0af_3000, 32'hc612_0000,
		32'hc633_6400, 32'hcb00_7100, 32'he000_0000
	};
	localparam int LAN_LENS [15] = '{8, 8, 8, 16, 12, 24, 24, 24, 24, 16, 24, 15, 24, 24, 4};

	typedef struct packed {
		bit        inbound;
		bit        remote_known;
		bit [15:0] prefix_id;
		bit [31:0] gap_us;
		bit [15:0] length_out;
		bit        window_last;
	} features_t;

	logic                            clk;
	logic                            arst_n;
	logic [pdpf_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [0:0]                      s_tuser;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [pdpf_pkg::CFG_W-1:0]      cfg_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [pdpf_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tlast;
	logic                            m_tvalid;
	logic                            m_tready;

	// Predicted state of the block.
	bit [31:0]                  prefix_words [pdpf_pkg::TABLE_DEPTH];
	bit [63:0]                  last_arrival;
	int                         window_pos;
	bit [pdpf_pkg::CFG_W-1:0]   entry_count_reg;

	features_t        expected_features [$];
	bit [63:0]        arrival_clock;
	int               error_count;
	int               sender_idle_pct;
	int               sink_stall_pct;
	bit               hold_off_request;

	packet_direction_prefix_features uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.cfg_data  (cfg_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Address classification.
	function automatic bit in_net(input bit [31:0] addr, input bit [31:0] net, input int len);
		bit [31:0] mask;
		mask = (len == 0) ? 32'h0 : ~(32'hffff_ffff >> len);
		return (addr & mask) == net;
	endfunction

	function automatic bit lan_member(input bit [31:0] addr);
		bit hit;
		hit = in_net(addr, 32'hc000_0000, 24) && addr != 32'hc000_0009 && addr != 32'hc000_000a;
		for (int k = 0; k < 15; k++) begin
			hit = hit | in_net(addr, LAN_NETS[k], LAN_LENS[k]);
		end
		return hit;
	endfunction

	function automatic bit wan_member(input bit [31:0] addr);
		return !lan_member(addr) && !in_net(addr, 32'h6440_0000, 10) &&
			!in_net(addr, 32'he000_0000, 4);
	endfunction

	function automatic int searched_entries();
		return (entry_count_reg > pdpf_pkg::TABLE_DEPTH) ? pdpf_pkg::TABLE_DEPTH :
			int'(entry_count_reg);
	endfunction

	// Binary search over the sorted prefix table.
	function automatic bit [15:0] lookup_prefix_id(input bit [15:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = searched_entries();
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (prefix_words[mid][31:16] == key)
				return prefix_words[mid][15:0];
			if (prefix_words[mid][31:16] < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		return 16'h0;
	endfunction

	// Features of one packet; advances the window and the previous timestamp.
	function automatic features_t predict_features(input bit [31:0] src, input bit [31:0] dst,
			input bit [63:0] t, input bit [15:0] len);
		features_t f;
		bit        src_lan;
		bit        dst_lan;
		bit [31:0] remote;
		bit [63:0] delta;
		f = '0;
		remote = 32'h0;
		src_lan = lan_member(src);
		dst_lan = lan_member(dst);
		if (src_lan && wan_member(dst)) begin
			f.remote_known = 1'b1;
			remote = dst;
		end else if (dst_lan && wan_member(src)) begin
			f.remote_known = 1'b1;
			f.inbound = 1'b1;
			remote = src;
		end else if (dst_lan && !src_lan) begin
			f.inbound = 1'b1;
		end
		if (f.remote_known)
			f.prefix_id = lookup_prefix_id(remote[31:16]);
		if (window_pos != 0 && t >= last_arrival) begin
			delta = t - last_arrival;
			f.gap_us = (delta > 64'hffff_ffff) ? 32'hffff_ffff : delta[31:0];
		end
		last_arrival = t;
		f.window_last = (window_pos + 1 >= pdpf_pkg::WINDOW_LENGTH);
		window_pos = f.window_last ? 0 : window_pos + 1;
		f.length_out = len;
		return f;
	endfunction

	// Address generators for the random traffic.
	function automatic bit [31:0] lan_address();
		int k;
		k = $urandom_range(0, 14);
		return LAN_NETS[k] | ($urandom & (32'hffff_ffff >> LAN_LENS[k]));
	endfunction

	function automatic bit [31:0] table_address();
		int used;
		bit [15:0] low;
		used = searched_entries();
		low = $urandom_range(0, 65535);
		if (used == 0)
			return $urandom;
		return {prefix_words[$urandom_range(0, used - 1)][31:16], low};
	endfunction

	function automatic bit [31:0] any_address();
		case ($urandom_range(0, 5))
			0: return lan_address();
			1: return ($urandom_range(0, 2) == 0) ? 32'hc000_0009 + $urandom_range(0, 1) :
				32'hc000_0000 | $urandom_range(0, 255);
			2: return 32'h6440_0000 | ($urandom & 32'h003f_ffff);
			3: return 32'he000_0000 | ($urandom & 32'h0fff_ffff);
			4: return table_address();
			default: return $urandom;
		endcase
	endfunction

	function automatic bit [31:0] remote_candidate();
		return ($urandom_range(0, 9) < 6) ? table_address() : any_address();
	endfunction

	// Sends one request; the prediction is taken in the cycle that accepts it.
	task automatic send_item(input logic cmd, input bit [31:0] src, input bit [31:0] dst,
			input bit [63:0] t, input bit [15:0] len, input bit [9:0] slot,
			input bit [15:0] pfx, input bit [15:0] id);
		bit taken;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {6'd0, id, pfx, slot, len, t, dst, src};
		s_tuser <= cmd;
		s_tvalid <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			if (taken) begin
				if (cmd == pdpf_pkg::CMD_TABLE_WRITE)
					prefix_words[slot] = {pfx, id};
				else
					expected_features.push_back(predict_features(src, dst, t, len));
			end
			@(posedge clk);
		end
	endtask

	task automatic send_packet(input bit [31:0] src, input bit [31:0] dst, input bit [63:0] t,
			input bit [15:0] len);
		send_item(pdpf_pkg::CMD_PACKET, src, dst, t, len, 10'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	task automatic send_entry(input bit [9:0] slot, input bit [15:0] pfx, input bit [15:0] id);
		send_item(pdpf_pkg::CMD_TABLE_WRITE, $urandom, $urandom, {$urandom, $urandom},
			16'($urandom), slot, pfx, id);
	endtask

	// Holds the input off until every outstanding result has arrived.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_features.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_entry_count(input bit [pdpf_pkg::CFG_W-1:0] value);
		bit taken;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			if (taken)
				entry_count_reg = value;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_packet();
		bit [31:0] src;
		bit [31:0] dst;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				src = lan_address();
				dst = remote_candidate();
			end
			4, 5, 6: begin
				src = remote_candidate();
				dst = lan_address();
			end
			default: begin
				src = any_address();
				dst = any_address();
			end
		endcase
		// Mostly forward steps, with jumps, backward steps and saturating gaps.
		case ($urandom_range(0, 19))
			0: arrival_clock = {$urandom, $urandom};
			1: arrival_clock = arrival_clock - $urandom_range(1, 1000);
			2: arrival_clock = arrival_clock + {$urandom_range(1, 255), $urandom};
			3: ;
			default: arrival_clock = arrival_clock + $urandom_range(0, 20000);
		endcase
		send_packet(src, dst, arrival_clock, 16'($urandom));
	endtask

	// Rewrites one slot, usually keeping the table in ascending order.
	task automatic send_random_entry();
		bit [9:0]  slot;
		bit [15:0] lo;
		bit [15:0] hi;
		bit [15:0] pfx;
		slot = $urandom_range(0, pdpf_pkg::TABLE_DEPTH - 1);
		lo = (slot > 0) ? prefix_words[slot - 1][31:16] : 16'h0000;
		hi = (slot < pdpf_pkg::TABLE_DEPTH - 1) ? prefix_words[slot + 1][31:16] : 16'hffff;
		if (lo <= hi && $urandom_range(0, 9) != 0)
			pfx = $urandom_range(hi, lo);
		else
			pfx = $urandom;
		send_entry(slot, pfx, $urandom_range(1, 65535));
	endtask

	// Address classes and timestamp cases with an empty table.
	task automatic test_classes_empty_table();
		sender_idle_pct = 0;
		sink_stall_pct = 0;
		send_packet(32'h0a01_0203, 32'h0808_0808, 64'd0, 16'h0000);
		send_packet(32'h0808_0808, 32'hc0a8_0101, 64'd100, 16'hffff);
		send_packet(32'h0a00_0001, 32'hac10_0001, 64'd100, 16'h1234);
		send_packet(32'h6440_0001, 32'h0a00_0001, 64'd50, 16'h0040);
		send_packet(32'h0a00_0001, 32'he000_0001, 64'h1_0000_0037, 16'h05dc);
		send_packet(32'h0102_0304, 32'h0808_0808, 64'h1_0000_0040, 16'h0001);
		send_packet(32'hc0a8_0001, 32'hc000_0009, 64'h1_0000_1040, 16'h0002);
		send_packet(32'hc000_000a, 32'hc000_0005, 64'h1_0000_1041, 16'h0003);
		send_packet(32'hffff_ffff, 32'h0000_0000, 64'hffff_ffff_ffff_ffff, 16'haaaa);
		send_packet(32'h0000_0000, 32'hffff_ffff, 64'd0, 16'h5555);
		send_packet(32'h6440_0000, 32'h647f_ffff, 64'd10, 16'h0100);
		send_packet(32'h7f00_0001, 32'ha9fe_0101, 64'd20, 16'h0200);
		send_packet(32'hc613_0000, 32'hc614_0000, 64'd30, 16'h0300);
		arrival_clock = 64'd30;
	endtask

	// Fills every slot in ascending order, then searches it at full size.
	task automatic test_table_load();
		int        probes [5] = '{100, 300, 512, 800, 650};
		bit [15:0] pfx;
		bit [15:0] id;
		for (int slot = 0; slot < pdpf_pkg::TABLE_DEPTH; slot++) begin
			pfx = (slot == 0) ? 16'h0000 : (slot == pdpf_pkg::TABLE_DEPTH - 1) ? 16'hffff :
				16'(slot * 64 + $urandom_range(0, 63));
			id = (slot == 0) ? 16'h0001 : (slot == pdpf_pkg::TABLE_DEPTH - 1) ? 16'hffff :
				16'($urandom_range(1, 65535));
			send_entry(10'(slot), pfx, id);
		end
		drain_results();
		write_entry_count(pdpf_pkg::CFG_W'(pdpf_pkg::TABLE_DEPTH));
		for (int k = 0; k < 4; k++) begin
			arrival_clock = arrival_clock + 7;
			send_packet(32'h0a00_0001, {prefix_words[probes[k]][31:16], 16'h1234},
				arrival_clock, 16'($urandom));
		end
		send_packet({prefix_words[probes[4]][31:16] + 16'd1, 16'h00ff}, 32'hc0a8_0002,
			arrival_clock, 16'($urandom));
	endtask

	// Small counts, counts above the table depth, and the empty table.
	task automatic test_entry_counts();
		bit [pdpf_pkg::CFG_W-1:0] counts [5] = '{1, 2, 2047, 1025, 0};
		for (int k = 0; k < 5; k++) begin
			drain_results();
			write_entry_count(counts[k]);
			repeat (2) send_random_packet();
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input bit [pdpf_pkg::CFG_W-1:0] count, input int items);
		drain_results();
		sender_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		write_entry_count(count);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 99) < 6)
				send_random_entry();
			else
				send_random_packet();
		end
	endtask

	// Long receiver hold-off while packets keep coming, then a full pause.
	task automatic test_backpressure();
		drain_results();
		sender_idle_pct = 0;
		sink_stall_pct = 0;
		write_entry_count(pdpf_pkg::CFG_W'(pdpf_pkg::TABLE_DEPTH));
		hold_off_request = 1'b1;
		repeat (40) send_random_packet();
		drain_results();
		repeat (40) send_random_packet();
	endtask

	// Receiver readiness, with a long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	// Compares each accepted result with the oldest prediction.
	initial begin
		features_t want;
		forever begin
			@(negedge clk);
			if (m_tvalid === 1'b1 && m_tready) begin
				if (expected_features.size() == 0) begin
					$error("result with no packet outstanding: %h", m_tdata);
					error_count++;
				end else begin
					want = expected_features.pop_front();
					check_field("inbound", want.inbound, m_tdata[0]);
					check_field("remote_known", want.remote_known, m_tdata[1]);
					check_field("prefix_id", want.prefix_id, m_tdata[17:2]);
					check_field("gap_us", want.gap_us, m_tdata[49:18]);
					check_field("length_out", want.length_out, m_tdata[65:50]);
					check_field("window_last", want.window_last, m_tlast);
				end
			end
		end
	end

	// Ends the run when nothing has been accepted for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL packet_direction_prefix_features");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tdata = '0;
		s_tuser = pdpf_pkg::CMD_PACKET;
		s_tvalid = 1'b0;
		cfg_data = '0;
		cfg_valid = 1'b0;
		error_count = 0;
		sender_idle_pct = 0;
		sink_stall_pct = 0;
		hold_off_request = 1'b0;
		last_arrival = 64'h0;
		window_pos = 0;
		entry_count_reg = '0;
		arrival_clock = 64'h0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_classes_empty_table();
		test_table_load();
		test_entry_counts();
		test_random_traffic(0, 0, pdpf_pkg::CFG_W'(pdpf_pkg::TABLE_DEPTH), 45);
		test_random_traffic(54, 0, pdpf_pkg::CFG_W'($urandom_range(1, 2047)), 45);
		test_backpressure();
		test_random_traffic(0, 54, 11'd2047, 45);
		test_random_traffic(31, 31, pdpf_pkg::CFG_W'($urandom_range(1, 1024)), 45);
		drain_results();

		if (error_count == 0)
			$display("PASS packet_direction_prefix_features");
		else
			$display("FAIL packet_direction_prefix_features");
		$finish;
	end

endmodule
